/* rtl/aabb_sweep_collision_pairs_unit_macros.svh */
// Assertion macros shared by the sweep unit RTL.
`ifndef AABB_SWEEP_COLLISION_PAIRS_UNIT_MACROS_SVH
`define AABB_SWEEP_COLLISION_PAIRS_UNIT_MACROS_SVH

// Same-cycle implication.
`define ASWP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASWP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aswp_pkg.sv */
// Types and constants for the sort-and-sweep box pair unit.
package aswp_pkg;

  localparam int MAX_BOXES_DEF = 16;
  localparam logic [15:0] THRESHOLD_Y_RESET = 16'd1024;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_FETCH  = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_PAIR = 2'd2;
  localparam logic [1:0] STATUS_DONE = 2'd3;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } box_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_ROT,
    OP_DROP,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     odd;
  } cell_ctl_t;

endpackage

/* rtl/aabb_sweep_collision_pairs_unit.sv */
// Top level: box chain, command sequencer and result register.
// Add, remove and start first rotate the chain back into alignment; remove then visits
// every entry once, start runs the sort passes, and fetch scans entries, rotating the
// chain to reach each entry. Requests are taken one at a time.
// The chain rotates one slot per cycle and runs one sort pass per cycle.
// Synchronous active-low reset empties the table, ends any sweep, threshold 1024.
module aabb_sweep_collision_pairs_unit #(
  parameter int MAX_BOXES = aswp_pkg::MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_obj_id,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_size_w,
  input  logic [15:0] in_size_h,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_first_id,
  output logic [7:0]  out_second_id,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  `include "aabb_sweep_collision_pairs_unit_macros.svh"

  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int IW = $clog2(MAX_BOXES);
  localparam logic [CW-1:0] N_C    = CW'(MAX_BOXES);
  localparam logic [CW-1:0] LAST_P = CW'(MAX_BOXES - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ALIGN  = 6'b000010,
    ST_REMOVE = 6'b000100,
    ST_SORT   = 6'b001000,
    ST_OUTER  = 6'b010000,
    ST_INNER  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, oi_r, oi_nxt, ii_r, ii_nxt;
  logic [CW-1:0] rem_r, rem_nxt, pass_r, pass_nxt;
  logic [IW-1:0] rot_r, rot_nxt, rot_inc;
  logic          active_r, active_nxt;
  logic [15:0]   thr_r;
  logic [1:0]    req_cmd_r, req_cmd_nxt;
  aswp_pkg::box_t req_box_r, req_box_nxt, ob_r, ob_nxt, head;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_first_r, out_first_nxt, out_second_r, out_second_nxt;
  aswp_pkg::cell_ctl_t ctl;
  aswp_pkg::box_t cell_box [MAX_BOXES];
  aswp_pkg::box_t zero_box;
  logic [CW-1:0] rot_ext;
  logic signed [17:0] ax, ay, bx, by, aw, ah, bw, bh;
  logic signed [16:0] gap;
  logic overlap, gap_over;

  assign zero_box = '0;
  assign head     = cell_box[0];

  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
    aswp_cell #(.IDX(k), .CW(CW)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .wr_box   (req_box_r),
      .left_box ((k == 0) ? zero_box : cell_box[(k == 0) ? 0 : k - 1]),
      .right_box((k == MAX_BOXES - 1) ? zero_box
                 : cell_box[(k == MAX_BOXES - 1) ? k : k + 1]),
      .head_box (head),
      .box      (cell_box[k])
    );
  end

  assign rot_ext = CW'(rot_r);
  assign rot_inc = (rot_ext + 1'b1 == count_r) ? '0 : rot_r + 1'b1;

  // outer box a, head of chain b
  assign ax = 18'(signed'(ob_r.x));
  assign ay = 18'(signed'(ob_r.y));
  assign bx = 18'(signed'(head.x));
  assign by = 18'(signed'(head.y));
  assign aw = signed'({2'b00, ob_r.w});
  assign ah = signed'({2'b00, ob_r.h});
  assign bw = signed'({2'b00, head.w});
  assign bh = signed'({2'b00, head.h});
  assign overlap = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
  assign gap      = 17'(signed'(head.y)) - 17'(signed'(ob_r.y));
  assign gap_over = gap > signed'({1'b0, thr_r});

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rot_nxt        = rot_r;
    oi_nxt         = oi_r;
    ii_nxt         = ii_r;
    rem_nxt        = rem_r;
    pass_nxt       = pass_r;
    active_nxt     = active_r;
    req_cmd_nxt    = req_cmd_r;
    req_box_nxt    = req_box_r;
    ob_nxt         = ob_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    ctl.op         = aswp_pkg::OP_HOLD;
    ctl.odd        = pass_r[0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          req_cmd_nxt = in_cmd;
          req_box_nxt = '{id: in_obj_id, x: in_pos_x, y: in_pos_y,
                          w: in_size_w, h: in_size_h};
          if (in_cmd == aswp_pkg::CMD_FETCH) begin
            if (active_r) begin
              state_nxt = ST_OUTER;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = aswp_pkg::STATUS_DONE;
              out_first_nxt  = '0;
              out_second_nxt = '0;
            end
          end else begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        if (rot_r != '0) begin
          ctl.op  = aswp_pkg::OP_ROT;
          rot_nxt = rot_inc;
        end else begin
          out_first_nxt  = '0;
          out_second_nxt = '0;
          out_status_nxt = aswp_pkg::STATUS_OK;
          case (req_cmd_r)
            aswp_pkg::CMD_ADD: begin
              active_nxt    = 1'b0;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
              if (count_r < N_C) begin
                ctl.op    = aswp_pkg::OP_WRITE;
                count_nxt = count_r + 1'b1;
              end else begin
                out_status_nxt = aswp_pkg::STATUS_FULL;
              end
            end
            aswp_pkg::CMD_REMOVE: begin
              active_nxt = 1'b0;
              rem_nxt    = count_r;
              state_nxt  = ST_REMOVE;
            end
            default: begin
              pass_nxt  = '0;
              state_nxt = ST_SORT;
            end
          endcase
        end
      end
      ST_REMOVE: begin
        // head leaves the chain on a match, else goes to the tail
        if (rem_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = aswp_pkg::STATUS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          rem_nxt = rem_r - 1'b1;
          if (head.id == req_box_r.id) begin
            ctl.op    = aswp_pkg::OP_DROP;
            count_nxt = count_r - 1'b1;
          end else begin
            ctl.op = aswp_pkg::OP_ROT;
          end
        end
      end
      ST_SORT: begin
        ctl.op   = aswp_pkg::OP_SORT;
        pass_nxt = pass_r + 1'b1;
        if (pass_r == LAST_P) begin
          active_nxt     = 1'b1;
          oi_nxt         = '0;
          ii_nxt         = CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = aswp_pkg::STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      ST_OUTER: begin
        if (oi_r >= count_r) begin
          active_nxt     = 1'b0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = aswp_pkg::STATUS_DONE;
          out_first_nxt  = '0;
          out_second_nxt = '0;
          state_nxt      = ST_IDLE;
        end else if (rot_ext != oi_r) begin
          ctl.op  = aswp_pkg::OP_ROT;
          rot_nxt = rot_inc;
        end else begin
          ob_nxt    = head;
          state_nxt = ST_INNER;
        end
      end
      ST_INNER: begin
        if (ii_r >= count_r) begin
          oi_nxt    = oi_r + 1'b1;
          ii_nxt    = oi_r + CW'(2);
          state_nxt = ST_OUTER;
        end else if (rot_ext != ii_r) begin
          ctl.op  = aswp_pkg::OP_ROT;
          rot_nxt = rot_inc;
        end else if (gap_over) begin
          oi_nxt    = oi_r + 1'b1;
          ii_nxt    = oi_r + CW'(2);
          state_nxt = ST_OUTER;
        end else begin
          ii_nxt = ii_r + 1'b1;
          if (overlap) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = aswp_pkg::STATUS_PAIR;
            out_first_nxt  = ob_r.id;
            out_second_nxt = head.id;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rot_r       <= '0;
      oi_r        <= '0;
      ii_r        <= '0;
      rem_r       <= '0;
      pass_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= aswp_pkg::THRESHOLD_Y_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rot_r       <= rot_nxt;
      oi_r        <= oi_nxt;
      ii_r        <= ii_nxt;
      rem_r       <= rem_nxt;
      pass_r      <= pass_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req_cmd_r    <= req_cmd_nxt;
    req_box_r    <= req_box_nxt;
    ob_r         <= ob_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_first_id  = out_first_r;
  assign out_second_id = out_second_r;

  `ASWP_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")
  `ASWP_ASSERT_NOW(a_count_max, 1'b1, count_r <= N_C, "box count overflow")
  `ASWP_ASSERT_NOW(a_empty_aligned, count_r == '0, rot_r == '0, "rotated empty chain")
  `ASWP_ASSERT_NOW(a_idle_outer, (state_r == ST_IDLE) && active_r, oi_r <= count_r,
                   "outer index past table")

endmodule

/* rtl/aswp_cell.sv */
// One slot of the box chain: holds a box and trades it with its neighbors.
module aswp_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic              clk,
  input  aswp_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]     count,
  input  aswp_pkg::box_t    wr_box,
  input  aswp_pkg::box_t    left_box,
  input  aswp_pkg::box_t    right_box,
  input  aswp_pkg::box_t    head_box,
  output aswp_pkg::box_t    box
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);
  localparam logic          PAR    = 1'(IDX % 2);
  localparam logic          LPAR   = 1'((IDX + 1) % 2);
  localparam logic          HAS_L  = (IDX > 0);

  aswp_pkg::box_t box_r, box_nxt;
  logic not_last, swap_lo, swap_hi;

  assign not_last = IDX_P1 < count;
  assign swap_lo  = (PAR == ctl.odd) && not_last &&
                    ($signed(box_r.y) > $signed(right_box.y));
  assign swap_hi  = HAS_L && (LPAR == ctl.odd) && (IDX_C < count) &&
                    ($signed(left_box.y) > $signed(box_r.y));

  always_comb begin
    box_nxt = box_r;
    case (ctl.op)
      aswp_pkg::OP_WRITE: if (IDX_C == count) box_nxt = wr_box;
      aswp_pkg::OP_ROT: begin
        if (not_last) box_nxt = right_box;
        else if (IDX_P1 == count) box_nxt = head_box;
      end
      aswp_pkg::OP_DROP: if (not_last) box_nxt = right_box;
      aswp_pkg::OP_SORT: begin
        if (swap_lo) box_nxt = right_box;
        else if (swap_hi) box_nxt = left_box;
      end
      default: box_nxt = box_r;
    endcase
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

  assign box = box_r;

endmodule
